// ===== hw/rtl/dsm_pkg.sv =====
// Package for the DFA state minimizer: shared constants, codes and types.
// No dependencies; used by every module of the block except dsm_ram.
package dsm_pkg;

   localparam int MAX_STATES_DEF = 32;
   localparam int SYMBOLS_DEF    = 256;

   localparam int GROUP_W     = 32;
   localparam int GROUP_DEPTH = 32;
   localparam int GIDX_W      = 5;
   localparam int GCNT_W      = 6;
   localparam int KEY_W       = 6;
   localparam int NKEYS       = 33;
   localparam int ADDR_MAX_W  = 13;
   localparam int STATE_W     = 5;
   localparam int NCOUNT_W    = 6;
   localparam int TCNT_W      = 14;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MARK  = 2'd2,
      OP_RUN   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_MARK  = 2'd2,
      CMD_RUN   = 2'd3
   } cmd_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ACCEPT = 2'd1;
   localparam logic [1:0] ST_NO_TRANS  = 2'd2;

   typedef struct packed {
      cmd_type                kind;
      logic [ADDR_MAX_W-1:0]  addr;
      logic [STATE_W-1:0]     state;
      logic [STATE_W-1:0]     target;
      logic [NCOUNT_W-1:0]    count;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic init_busy;
   } flow_type;

endpackage

// ===== hw/rtl/dsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dsm_front.sv =====
// Front end: takes items off the request channel, drops out-of-range loads
// and marks, and turns the rest into queue commands. Depends on dsm_pkg.
module dsm_front import dsm_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF,
   parameter int SYMBOLS    = SYMBOLS_DEF
) (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [4:0]          req_from_state,
   input  logic [7:0]          req_symbol,
   input  logic [4:0]          req_to_state,
   input  logic [5:0]          req_node_count,
   input  flow_type            flow,
   output logic                push,
   output cmd_entry_type       entry
);

   localparam int USE = (MAX_STATES < 32) ? MAX_STATES : 32;
   localparam int SW  = $clog2(USE);
   localparam int AW  = $clog2(USE * SYMBOLS);
   localparam logic [5:0]    USE_C  = 6'(USE);
   localparam logic [8:0]    SYM_C  = 9'(SYMBOLS);
   localparam logic [AW-1:0] STRIDE = AW'(SYMBOLS);

   logic          from_ok;
   logic          to_ok;
   logic          sym_ok;
   logic          keep;
   logic [AW-1:0] addr;

   assign req_stall = flow.full | flow.init_busy;

   always_comb begin
      from_ok = {1'b0, req_from_state} < USE_C;
      to_ok   = {1'b0, req_to_state} < USE_C;
      sym_ok  = {1'b0, req_symbol} < SYM_C;
      addr    = AW'(SW'(req_from_state)) * STRIDE + AW'(req_symbol);

      entry.addr   = ADDR_MAX_W'(addr);
      entry.state  = req_from_state;
      entry.target = req_to_state;
      entry.count  = (req_node_count > USE_C) ? USE_C : req_node_count;
      entry.kind   = CMD_RUN;
      keep         = 1'b1;
      case (op_type'(req_op))
         OP_CLEAR: begin
            entry.kind = CMD_CLEAR;
         end
         OP_LOAD: begin
            entry.kind = CMD_LOAD;
            keep       = from_ok & to_ok & sym_ok;
         end
         OP_MARK: begin
            entry.kind = CMD_MARK;
            keep       = from_ok;
         end
         default: begin
            entry.kind = CMD_RUN;
         end
      endcase
      push = req_valid & ~req_stall & keep;
   end

endmodule

// ===== hw/rtl/dsm_queue.sv =====
// Two-entry command queue between the front end and the execution unit.
// Depends on dsm_pkg for the command type.
module dsm_queue import dsm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   input  logic          pop,
   output logic          head_valid,
   output cmd_entry_type head,
   output logic          full
);

   cmd_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign head_valid = (count_ff != 2'd0);
   assign full       = (count_ff == 2'd2);
   assign head       = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/dsm_back.sv =====
// Execution unit: transition store, accepting mask, partition refinement
// sequencer and result register. Depends on dsm_pkg and dsm_ram.
module dsm_back import dsm_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF,
   parameter int SYMBOLS    = SYMBOLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_entry_type       q_head,
   output logic                q_pop,
   output logic                init_busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [GROUP_W-1:0]  rsp_group_members,
   output logic [GIDX_W-1:0]   rsp_group_position,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   localparam int USE   = (MAX_STATES < 32) ? MAX_STATES : 32;
   localparam int SW    = $clog2(USE);
   localparam int YW    = $clog2(SYMBOLS);
   localparam int DEPTH = USE * SYMBOLS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]     STRIDE    = AW'(SYMBOLS);
   localparam logic [AW-1:0]     CLR_LAST  = AW'(DEPTH - 1);
   localparam logic [SW-1:0]     M_LAST    = SW'(USE - 1);
   localparam logic [YW-1:0]     SYM_LAST  = YW'(SYMBOLS - 1);
   localparam logic [TCNT_W-1:0] TCNT_MAX  = '1;

   typedef enum logic [19:0] {
      S_CLR    = 20'h00001,
      S_IDLE   = 20'h00002,
      S_LD_RD  = 20'h00004,
      S_LD_WR  = 20'h00008,
      S_ERR    = 20'h00010,
      S_RUN0   = 20'h00020,
      S_RUN1   = 20'h00040,
      S_RB_CLR = 20'h00080,
      S_RB_RD  = 20'h00100,
      S_RB_WR  = 20'h00200,
      S_GL_RD  = 20'h00400,
      S_GL_WR  = 20'h00800,
      S_SCAN   = 20'h01000,
      S_DRAIN  = 20'h02000,
      S_EVAL   = 20'h04000,
      S_SH_RD  = 20'h08000,
      S_SH_WR  = 20'h10000,
      S_APPEND = 20'h20000,
      S_EM_RD  = 20'h40000,
      S_EM_WR  = 20'h80000
   } state_type;

   state_type           state_ff, state_in;
   cmd_entry_type       cmd_ff, cmd_in;
   logic [GROUP_W-1:0]  acc_ff, acc_in;
   logic [TCNT_W-1:0]   tcnt_ff, tcnt_in;
   logic [GCNT_W-1:0]   gcnt_ff, gcnt_in;
   logic [GCNT_W-1:0]   gi_ff, gi_in;
   logic [GCNT_W-1:0]   g_ff, g_in;
   logic [YW-1:0]       sym_ff, sym_in;
   logic [SW-1:0]       m_ff, m_in;
   logic [GROUP_W-1:0]  members_ff, members_in;
   logic [KEY_W-1:0]    keys_ff [GROUP_DEPTH];
   logic [KEY_W-1:0]    keys_in [GROUP_DEPTH];
   logic [NKEYS-1:0]    used_ff, used_in;
   logic                pos_v_ff [GROUP_DEPTH];
   logic                pos_v_in [GROUP_DEPTH];
   logic [GIDX_W-1:0]   pos_ff [GROUP_DEPTH];
   logic [GIDX_W-1:0]   pos_in [GROUP_DEPTH];
   logic                pv_ff, pv_in;
   logic [SW-1:0]       pm_ff, pm_in;
   logic                changed_ff, changed_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                init_ff, init_in;
   logic                out_v_ff, out_v_in;
   logic [GROUP_W-1:0]  out_members_ff, out_members_in;
   logic [GIDX_W-1:0]   out_pos_ff, out_pos_in;
   logic [1:0]          out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic                tr_we;
   logic [AW-1:0]       tr_waddr;
   logic [SW:0]         tr_wdata;
   logic [AW-1:0]       tr_raddr;
   logic [SW:0]         tr_rdata;
   logic                gl_we;
   logic [GIDX_W-1:0]   gl_waddr;
   logic [GROUP_W-1:0]  gl_wdata;
   logic [GIDX_W-1:0]   gl_raddr;
   logic [GROUP_W-1:0]  gl_rdata;

   logic                out_free;
   logic [SW-1:0]       tgt;
   logic [KEY_W-1:0]    key;
   logic [GROUP_W-1:0]  nonacc;
   logic [KEY_W-1:0]    cur_key;
   logic [GROUP_W-1:0]  sub_mask;
   logic [NKEYS-1:0]    used_rest;
   logic [GCNT_W-1:0]   g_next;

   dsm_ram #(.WIDTH(SW + 1), .DEPTH(DEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_waddr),
      .wr_data (tr_wdata),
      .rd_addr (tr_raddr),
      .rd_data (tr_rdata)
   );

   dsm_ram #(.WIDTH(GROUP_W), .DEPTH(GROUP_DEPTH)) u_group_ram (
      .clock   (clock),
      .wr_en   (gl_we),
      .wr_addr (gl_waddr),
      .wr_data (gl_wdata),
      .rd_addr (gl_raddr),
      .rd_data (gl_rdata)
   );

   assign init_busy          = init_ff;
   assign rsp_valid          = out_v_ff;
   assign rsp_group_members  = out_members_ff;
   assign rsp_group_position = out_pos_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last           = out_last_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      acc_in         = acc_ff;
      tcnt_in        = tcnt_ff;
      gcnt_in        = gcnt_ff;
      gi_in          = gi_ff;
      g_in           = g_ff;
      sym_in         = sym_ff;
      m_in           = m_ff;
      members_in     = members_ff;
      keys_in        = keys_ff;
      used_in        = used_ff;
      pos_v_in       = pos_v_ff;
      pos_in         = pos_ff;
      pv_in          = 1'b0;
      pm_in          = pm_ff;
      changed_in     = changed_ff;
      clr_in         = clr_ff;
      init_in        = init_ff;
      out_v_in       = out_v_ff;
      out_members_in = out_members_ff;
      out_pos_in     = out_pos_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      q_pop          = 1'b0;

      tr_we    = 1'b0;
      tr_waddr = cmd_ff.addr[AW-1:0];
      tr_wdata = '0;
      tr_raddr = cmd_ff.addr[AW-1:0];
      gl_we    = 1'b0;
      gl_waddr = gcnt_ff[GIDX_W-1:0];
      gl_wdata = '0;
      gl_raddr = g_ff[GIDX_W-1:0];

      out_free = ~out_v_ff | ~rsp_stall;
      if (out_v_ff && !rsp_stall) begin
         out_v_in = 1'b0;
      end

      // Key of the member whose transition was read last cycle: 0 for a dead
      // transition or a target in no group, otherwise group position + 1.
      tgt = tr_rdata[SW-1:0];
      key = '0;
      if (tr_rdata[SW] && pos_v_ff[GIDX_W'(tgt)]) begin
         key = {1'b0, pos_ff[GIDX_W'(tgt)]} + KEY_W'(1);
      end
      if (pv_ff) begin
         keys_in[GIDX_W'(pm_ff)] = key;
         used_in[key]            = 1'b1;
      end

      nonacc = '0;
      for (int s = 0; s < USE; s++) begin
         nonacc[s] = (NCOUNT_W'(s) < cmd_ff.count) & ~acc_ff[s];
      end

      cur_key = '0;
      for (int k = NKEYS - 1; k >= 0; k--) begin
         if (used_ff[k]) begin
            cur_key = KEY_W'(k);
         end
      end
      sub_mask = '0;
      for (int s = 0; s < USE; s++) begin
         sub_mask[s] = members_ff[s] & (keys_ff[s] == cur_key);
      end
      used_rest          = used_ff;
      used_rest[cur_key] = 1'b0;
      g_next             = g_ff + GCNT_W'(1);

      case (state_ff)
         S_CLR: begin
            tr_we    = 1'b1;
            tr_waddr = clr_ff;
            acc_in   = '0;
            tcnt_in  = '0;
            gcnt_in  = '0;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               clr_in   = '0;
               init_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               case (q_head.kind)
                  CMD_CLEAR: begin
                     state_in = S_CLR;
                  end
                  CMD_LOAD: begin
                     state_in = S_LD_RD;
                  end
                  CMD_MARK: begin
                     acc_in = acc_ff | (GROUP_W'(1) << q_head.state);
                  end
                  default: begin
                     gcnt_in = '0;
                     if (acc_ff == '0 || tcnt_ff == '0) begin
                        state_in = S_ERR;
                     end else begin
                        state_in = S_RUN0;
                     end
                  end
               endcase
            end
         end
         S_LD_RD: begin
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            if (!tr_rdata[SW]) begin
               tr_we    = 1'b1;
               tr_wdata = {1'b1, cmd_ff.target[SW-1:0]};
               if (tcnt_ff != TCNT_MAX) begin
                  tcnt_in = tcnt_ff + TCNT_W'(1);
               end
            end
            state_in = S_IDLE;
         end
         S_ERR: begin
            if (out_free) begin
               out_v_in       = 1'b1;
               out_members_in = '0;
               out_pos_in     = '0;
               out_status_in  = (acc_ff == '0) ? ST_NO_ACCEPT : ST_NO_TRANS;
               out_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_RUN0: begin
            gl_we    = 1'b1;
            gl_waddr = '0;
            gl_wdata = acc_ff;
            gcnt_in  = GCNT_W'(1);
            state_in = S_RUN1;
         end
         S_RUN1: begin
            if (nonacc != '0) begin
               gl_we    = 1'b1;
               gl_waddr = GIDX_W'(1);
               gl_wdata = nonacc;
               gcnt_in  = GCNT_W'(2);
            end
            gi_in      = '0;
            changed_in = 1'b0;
            state_in   = S_RB_CLR;
         end
         S_RB_CLR: begin
            for (int s = 0; s < GROUP_DEPTH; s++) begin
               pos_v_in[s] = 1'b0;
            end
            g_in     = '0;
            state_in = S_RB_RD;
         end
         S_RB_RD: begin
            if (g_ff < gcnt_ff) begin
               state_in = S_RB_WR;
            end else begin
               state_in = S_GL_RD;
            end
         end
         S_RB_WR: begin
            for (int s = 0; s < GROUP_DEPTH; s++) begin
               if (gl_rdata[s]) begin
                  pos_v_in[s] = 1'b1;
                  pos_in[s]   = g_ff[GIDX_W-1:0];
               end
            end
            g_in     = g_next;
            state_in = S_RB_RD;
         end
         S_GL_RD: begin
            gl_raddr = gi_ff[GIDX_W-1:0];
            if (gi_ff < gcnt_ff) begin
               state_in = S_GL_WR;
            end else if (changed_ff) begin
               changed_in = 1'b0;
               gi_in      = '0;
            end else begin
               g_in     = '0;
               state_in = S_EM_RD;
            end
         end
         S_GL_WR: begin
            members_in = gl_rdata;
            sym_in     = '0;
            m_in       = '0;
            used_in    = '0;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            tr_raddr = AW'(m_ff) * STRIDE + AW'(sym_ff);
            pv_in    = members_ff[GIDX_W'(m_ff)];
            pm_in    = m_ff;
            m_in     = m_ff + SW'(1);
            if (m_ff == M_LAST) begin
               m_in     = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if ((used_ff & (used_ff - NKEYS'(1))) != '0) begin
               g_in     = gi_ff;
               state_in = S_SH_RD;
            end else if (sym_ff == SYM_LAST) begin
               gi_in    = gi_ff + GCNT_W'(1);
               state_in = S_GL_RD;
            end else begin
               sym_in   = sym_ff + YW'(1);
               used_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SH_RD: begin
            gl_raddr = g_next[GIDX_W-1:0];
            if (g_next < gcnt_ff) begin
               state_in = S_SH_WR;
            end else begin
               gcnt_in  = gcnt_ff - GCNT_W'(1);
               state_in = S_APPEND;
            end
         end
         S_SH_WR: begin
            gl_we    = 1'b1;
            gl_waddr = g_ff[GIDX_W-1:0];
            gl_wdata = gl_rdata;
            g_in     = g_next;
            state_in = S_SH_RD;
         end
         S_APPEND: begin
            gl_we    = 1'b1;
            gl_wdata = sub_mask;
            gcnt_in  = gcnt_ff + GCNT_W'(1);
            used_in  = used_rest;
            if (used_rest == '0) begin
               changed_in = 1'b1;
               state_in   = S_RB_CLR;
            end
         end
         S_EM_RD: begin
            state_in = S_EM_WR;
         end
         S_EM_WR: begin
            if (out_free) begin
               out_v_in       = 1'b1;
               out_members_in = gl_rdata;
               out_pos_in     = g_ff[GIDX_W-1:0];
               out_status_in  = ST_OK;
               out_last_in    = (g_next == gcnt_ff);
               g_in           = g_next;
               state_in       = (g_next == gcnt_ff) ? S_IDLE : S_EM_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         init_ff    <= 1'b1;
         clr_ff     <= '0;
         out_v_ff   <= 1'b0;
         pv_ff      <= 1'b0;
         changed_ff <= 1'b0;
         acc_ff     <= '0;
         tcnt_ff    <= '0;
         gcnt_ff    <= '0;
         gi_ff      <= '0;
         g_ff       <= '0;
         sym_ff     <= '0;
         m_ff       <= '0;
         used_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         init_ff    <= init_in;
         clr_ff     <= clr_in;
         out_v_ff   <= out_v_in;
         pv_ff      <= pv_in;
         changed_ff <= changed_in;
         acc_ff     <= acc_in;
         tcnt_ff    <= tcnt_in;
         gcnt_ff    <= gcnt_in;
         gi_ff      <= gi_in;
         g_ff       <= g_in;
         sym_ff     <= sym_in;
         m_ff       <= m_in;
         used_ff    <= used_in;
      end
      cmd_ff         <= cmd_in;
      members_ff     <= members_in;
      keys_ff        <= keys_in;
      pos_v_ff       <= pos_v_in;
      pos_ff         <= pos_in;
      pm_ff          <= pm_in;
      out_members_ff <= out_members_in;
      out_pos_ff     <= out_pos_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

endmodule

// ===== hw/rtl/dfa_state_minimizer.sv =====
// Top level of the DFA state minimizer: front end, command queue and
// execution unit. Depends on dsm_pkg, dsm_front, dsm_queue and dsm_back.
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_valid / req_stall  op, from_state, symbol,
//                                               to_state, node_count
//   rsp_*     out        rsp_valid / rsp_stall  group_members,
//                                               group_position, status, last
//
// Work: a mark item is handled in the execution unit's idle state; a load
// item reads the transition store (to keep the first load of a pair) and
// then writes it. A clear item sweeps the transition store, one entry per
// cycle, over (the smaller of MAX_STATES and 32) * SYMBOLS entries, since
// only that many states are stored. A run item walks every group, and for
// each group every symbol, reading one transition per cycle; every split
// then rewrites the group list and rebuilds the state-to-group map, and
// passes repeat until none splits.
// Reset: the same sweep as a clear follows reset, and no item is accepted
// until it ends.
// Stalls: a two-entry queue decouples the request side from the execution
// unit. The result register holds one result, and the execution unit waits
// while that register is full and rsp_stall is high.
module dfa_state_minimizer import dsm_pkg::*; #(
   parameter int MAX_STATES = MAX_STATES_DEF,
   parameter int SYMBOLS    = SYMBOLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [4:0]          req_from_state,
   input  logic [7:0]          req_symbol,
   input  logic [4:0]          req_to_state,
   input  logic [5:0]          req_node_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [GROUP_W-1:0]  rsp_group_members,
   output logic [GIDX_W-1:0]   rsp_group_position,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   flow_type      flow;
   logic          q_push;
   cmd_entry_type q_push_entry;
   logic          q_pop;
   logic          q_valid;
   cmd_entry_type q_head;
   logic          q_full;
   logic          init_busy;

   assign flow.full      = q_full;
   assign flow.init_busy = init_busy;

   // The front end classifies each item and drops loads and marks that name
   // a state or symbol outside the stored range.
   dsm_front #(.MAX_STATES(MAX_STATES), .SYMBOLS(SYMBOLS)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_from_state (req_from_state),
      .req_symbol     (req_symbol),
      .req_to_state   (req_to_state),
      .req_node_count (req_node_count),
      .flow           (flow),
      .push           (q_push),
      .entry          (q_push_entry)
   );

   dsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head),
      .full       (q_full)
   );

   // The execution unit pops one command at a time and runs it to the end.
   dsm_back #(.MAX_STATES(MAX_STATES), .SYMBOLS(SYMBOLS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .init_busy          (init_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_group_members  (rsp_group_members),
      .rsp_group_position (rsp_group_position),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last)
   );

   // The queue is never written while it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("command queue written while full");

   // Nothing is popped from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command queue popped while empty");

   // An error result is a single, empty, final item.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_last && rsp_group_members == '0))
      else $error("error result is not a single empty item");

   // While the store is swept after reset, no item is taken.
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> req_stall)
      else $error("item taken during the store sweep");

endmodule
